// ----- hdl/xmbs_pkg.sv -----
// XMODEM block sender: shared types, protocol characters, phase codes and CRC-16 step.
// No dependencies; used by the top level, the checker and the testbench.
package xmbs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = 8;

  localparam logic [IDX_W-1:0] HDR_BYTES  = IDX_W'(3);
  localparam logic [IDX_W-1:0] DATA_END   = IDX_W'(3 + BLOCK_BYTES);
  localparam logic [CNT_W-1:0] BLOCK_FULL = CNT_W'(BLOCK_BYTES);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [1:0] OP_LINE_RX = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_TX_SLOT = 2'd2;

  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_LOAD    = 4'd1;
  localparam logic [3:0] PH_SEND    = 4'd2;
  localparam logic [3:0] PH_ANSWER  = 4'd3;
  localparam logic [3:0] PH_EOT     = 4'd4;
  localparam logic [3:0] PH_EOTWAIT = 4'd5;
  localparam logic [3:0] PH_DONE    = 4'd6;
  localparam logic [3:0] PH_CANCEL  = 4'd7;
  localparam logic [3:0] PH_ERROR   = 4'd8;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] phase_code;
    logic [7:0] current_block;
    logic       payload_taken;
  } xmbs_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- hdl/xmbs_if.sv -----
// XMODEM block sender: valid/ready channel interfaces for commands and results.
// No dependencies.
interface xmbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       last_payload;

  modport source (output valid, output opcode, output data_byte, output last_payload,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input last_payload,
                output ready);
endinterface

interface xmbs_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [3:0] phase_code;
  logic [7:0] current_block;
  logic       payload_taken;

  modport source (output valid, output tx_valid, output tx_byte, output phase_code,
                  output current_block, output payload_taken, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input phase_code,
                input current_block, input payload_taken, output ready);
endinterface

// ----- hdl/xmodem_block_sender_unit.sv -----
// XMODEM block sender top level: protocol state, 128-byte block memory, result queue.
// Depends on xmbs_pkg and the channel interfaces in xmbs_if.sv.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        opcode, data_byte, last_payload
//   out_ch    out  valid/ready        tx_valid, tx_byte, phase_code, current_block,
//                                     payload_taken
//
// One command per cycle while in_ch is ready, one result per command; results are registered.
// Block bytes come from a registered memory read, prefetched in the cycle before the
// transmit slot that sends them, so sending never waits on the memory.
// Two-entry result queue: in_ch stays ready while one result waits on out_ch.
// Reset is synchronous; the block memory is not cleared.
module xmodem_block_sender_unit
  import xmbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  xmbs_in_if.sink    in_ch,
  xmbs_out_if.source out_ch
);

  logic [3:0]       phase_r, phase_nxt;
  logic             use_crc_r, use_crc_nxt;
  logic [7:0]       block_count_r, block_count_nxt;
  logic [CNT_W-1:0] fill_count_r, fill_count_nxt;
  logic             final_block_r, final_block_nxt;
  logic [IDX_W-1:0] send_index_r, send_index_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  logic [15:0]      running_crc_r, running_crc_nxt;

  logic [7:0]       block_mem [BLOCK_BYTES];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] rd_index;
  logic [ADDR_W-1:0] rd_addr;
  logic             mem_wr;

  logic             in_xfer;
  logic             out_xfer;
  logic [IDX_W-1:0] data_pos;
  logic [7:0]       data_byte_tx;
  logic [CNT_W-1:0] fill_inc;
  xmbs_result_t     res;

  xmbs_result_t     head_r, head_nxt;
  logic             head_valid_r, head_valid_nxt;
  xmbs_result_t     skid_r, skid_nxt;
  logic             skid_valid_r, skid_valid_nxt;

  assign in_ch.ready = !skid_valid_r;
  assign in_xfer     = in_ch.valid && !skid_valid_r;
  assign out_xfer    = head_valid_r && out_ch.ready;

  assign data_pos     = send_index_r - HDR_BYTES;
  assign data_byte_tx = ({1'b0, data_pos} < {1'b0, fill_count_r}) ? rd_data_r : 8'h00;
  assign fill_inc     = fill_count_r + CNT_W'(1);

  always_comb begin
    phase_nxt       = phase_r;
    use_crc_nxt     = use_crc_r;
    block_count_nxt = block_count_r;
    fill_count_nxt  = fill_count_r;
    final_block_nxt = final_block_r;
    send_index_nxt  = send_index_r;
    running_sum_nxt = running_sum_r;
    running_crc_nxt = running_crc_r;
    mem_wr          = 1'b0;
    res             = '0;

    if (in_xfer) begin
      unique case (in_ch.opcode)
        OP_LINE_RX: begin
          priority if (phase_r == PH_START) begin
            priority if (in_ch.data_byte == CH_NAK) begin
              use_crc_nxt = 1'b0;
              phase_nxt   = PH_LOAD;
            end else if (in_ch.data_byte == CH_C) begin
              use_crc_nxt = 1'b1;
              phase_nxt   = PH_LOAD;
            end else if (in_ch.data_byte != 8'h00) begin
              phase_nxt = PH_ERROR;
            end else begin
            end
          end else if (phase_r == PH_ANSWER) begin
            priority if (in_ch.data_byte == CH_NAK) begin
              phase_nxt       = PH_SEND;
              send_index_nxt  = '0;
              running_sum_nxt = '0;
              running_crc_nxt = '0;
            end else if (in_ch.data_byte == CH_CAN) begin
              phase_nxt = PH_CANCEL;
            end else if (in_ch.data_byte != 8'h00) begin
              if (final_block_r) begin
                phase_nxt = PH_EOT;
              end else begin
                block_count_nxt = block_count_r + 8'd1;
                fill_count_nxt  = '0;
                phase_nxt       = PH_LOAD;
              end
            end else begin
            end
          end else if (phase_r == PH_EOTWAIT) begin
            phase_nxt = (in_ch.data_byte == CH_ACK) ? PH_DONE : PH_EOT;
          end else begin
          end
        end
        OP_LOAD: begin
          if (phase_r == PH_LOAD && fill_count_r < BLOCK_FULL) begin
            mem_wr            = 1'b1;
            fill_count_nxt    = fill_inc;
            res.payload_taken = 1'b1;
            if (in_ch.last_payload) begin
              final_block_nxt = 1'b1;
            end
            if (in_ch.last_payload || fill_inc >= BLOCK_FULL) begin
              phase_nxt       = PH_SEND;
              send_index_nxt  = '0;
              running_sum_nxt = '0;
              running_crc_nxt = '0;
            end
          end
        end
        OP_TX_SLOT: begin
          if (phase_r == PH_SEND) begin
            res.tx_valid   = 1'b1;
            send_index_nxt = send_index_r + IDX_W'(1);
            priority if (send_index_r == IDX_W'(0)) begin
              res.tx_byte = CH_SOH;
            end else if (send_index_r == IDX_W'(1)) begin
              res.tx_byte = block_count_r;
            end else if (send_index_r == IDX_W'(2)) begin
              res.tx_byte = ~block_count_r;
            end else if (send_index_r < DATA_END) begin
              res.tx_byte     = data_byte_tx;
              running_sum_nxt = running_sum_r + data_byte_tx;
              running_crc_nxt = crc16_byte(running_crc_r, data_byte_tx);
            end else if (!use_crc_r) begin
              res.tx_byte = running_sum_r;
              phase_nxt   = PH_ANSWER;
            end else if (send_index_r == DATA_END) begin
              res.tx_byte = running_crc_r[15:8];
            end else begin
              res.tx_byte = running_crc_r[7:0];
              phase_nxt   = PH_ANSWER;
            end
          end else if (phase_r == PH_EOT) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = CH_EOT;
            phase_nxt    = PH_EOTWAIT;
          end
        end
        default: begin
        end
      endcase
    end

    res.phase_code    = phase_nxt;
    res.current_block = block_count_nxt;
  end

  assign rd_index = send_index_nxt - HDR_BYTES;
  assign rd_addr  = rd_index[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      block_mem[fill_count_r[ADDR_W-1:0]] <= in_ch.data_byte;
    end
    rd_data_r <= block_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      use_crc_r     <= 1'b0;
      block_count_r <= 8'd1;
      fill_count_r  <= '0;
      final_block_r <= 1'b0;
      send_index_r  <= '0;
      running_sum_r <= '0;
      running_crc_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      use_crc_r     <= use_crc_nxt;
      block_count_r <= block_count_nxt;
      fill_count_r  <= fill_count_nxt;
      final_block_r <= final_block_nxt;
      send_index_r  <= send_index_nxt;
      running_sum_r <= running_sum_nxt;
      running_crc_r <= running_crc_nxt;
    end
  end

  always_comb begin
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    priority if (!head_valid_r || out_xfer) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        head_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        head_nxt       = res;
        head_valid_nxt = in_xfer;
      end
    end else if (in_xfer) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = head_valid_r;
  assign out_ch.tx_valid      = head_r.tx_valid;
  assign out_ch.tx_byte       = head_r.tx_byte;
  assign out_ch.phase_code    = head_r.phase_code;
  assign out_ch.current_block = head_r.current_block;
  assign out_ch.payload_taken = head_r.payload_taken;

endmodule

// ----- hdl/xmbs_checker.sv -----
// XMODEM block sender: port-level checker and its bind to the top level.
// Depends on xmbs_pkg and xmodem_block_sender_unit.
module xmbs_checker
  import xmbs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic [3:0] phase_code,
  input logic       payload_taken
);

  a_tx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tx_valid |->
      phase_code == PH_SEND || phase_code == PH_ANSWER || phase_code == PH_EOTWAIT)
    else $error("transmit byte reported outside a sending phase");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tx_valid |-> tx_byte == 8'h00)
    else $error("idle slot carries a nonzero byte");

  a_taken_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_taken |->
      !tx_valid && (phase_code == PH_LOAD || phase_code == PH_SEND))
    else $error("payload stored outside loading");

  a_eot_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tx_valid && phase_code == PH_EOTWAIT |-> tx_byte == CH_EOT)
    else $error("EOT slot sent a byte other than EOT");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(phase_code))
    else $error("stalled result changed");

endmodule

bind xmodem_block_sender_unit xmbs_checker u_xmbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .tx_valid      (out_ch.tx_valid),
  .tx_byte       (out_ch.tx_byte),
  .phase_code    (out_ch.phase_code),
  .payload_taken (out_ch.payload_taken)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for xmodem_block_sender_unit: a directed table, then a short
// random session checked against a behavioral XMODEM sender model. Depends on xmbs_pkg,
// the channel interfaces in xmbs_if.sv and the top level.
`timescale 1ns / 100ps

module tb_top;
  import xmbs_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 40;
  localparam int HOLD_AT_ITEM   = 80;
  localparam int PAUSE_AT_ITEM  = 160;

  typedef struct {
    logic [1:0]   op;
    logic [7:0]   d;
    logic         last;
    bit           typed;
    xmbs_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xmbs_in_if  in_ch ();
  xmbs_out_if out_ch ();

  xmodem_block_sender_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sender model state
  logic [3:0]  sm_phase;
  bit          sm_crc_mode;
  logic [7:0]  sm_block;
  logic [7:0]  sm_store [BLOCK_BYTES];
  int          sm_fill;
  bit          sm_final;
  logic [7:0]  sm_slot;
  logic [7:0]  sm_sum;
  logic [15:0] sm_crc;

  xmbs_result_t expected_tx_q [$];
  stim_row_t    stim_rows [$];

  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;
  int  mismatches = 0;
  int  items_in = 0;
  int  results_seen = 0;
  int  blocks_done = 0;
  int  plan_blocks;
  int  final_len;
  bit  end_by_cancel;
  bit  hold_fired = 1'b0;
  bit  pause_fired = 1'b0;

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic begin_frame();
    sm_phase = PH_SEND;
    sm_slot = 8'd0;
    sm_sum = 8'd0;
    sm_crc = 16'd0;
  endtask

  task automatic model_transfer(input logic [1:0] op, input logic [7:0] d, input logic last,
                                output xmbs_result_t r);
    int p;
    logic [7:0] b;
    r = '0;
    case (op)
      OP_LINE_RX: begin
        if (sm_phase == PH_START) begin
          if (d == CH_NAK) begin
            sm_crc_mode = 1'b0;
            sm_phase = PH_LOAD;
          end else if (d == CH_C) begin
            sm_crc_mode = 1'b1;
            sm_phase = PH_LOAD;
          end else if (d != 8'h00) begin
            sm_phase = PH_ERROR;
          end
        end else if (sm_phase == PH_ANSWER) begin
          if (d == CH_NAK) begin
            begin_frame();
          end else if (d == CH_CAN) begin
            sm_phase = PH_CANCEL;
          end else if (d != 8'h00) begin
            if (sm_final) begin
              sm_phase = PH_EOT;
            end else begin
              sm_block = sm_block + 8'd1;
              sm_fill = 0;
              sm_phase = PH_LOAD;
            end
          end
        end else if (sm_phase == PH_EOTWAIT) begin
          sm_phase = (d == CH_ACK) ? PH_DONE : PH_EOT;
        end
      end
      OP_LOAD: begin
        if (sm_phase == PH_LOAD && sm_fill < BLOCK_BYTES) begin
          sm_store[sm_fill] = d;
          sm_fill++;
          r.payload_taken = 1'b1;
          if (last) sm_final = 1'b1;
          if (last || sm_fill >= BLOCK_BYTES) begin_frame();
        end
      end
      OP_TX_SLOT: begin
        if (sm_phase == PH_SEND) begin
          r.tx_valid = 1'b1;
          if (sm_slot == 8'd0) begin
            r.tx_byte = CH_SOH;
          end else if (sm_slot == 8'd1) begin
            r.tx_byte = sm_block;
          end else if (sm_slot == 8'd2) begin
            r.tx_byte = ~sm_block;
          end else if (int'(sm_slot) < 3 + BLOCK_BYTES) begin
            p = int'(sm_slot) - 3;
            b = (p < sm_fill) ? sm_store[p] : 8'h00;
            r.tx_byte = b;
            sm_sum = sm_sum + b;
            sm_crc = crc_ccitt_step(sm_crc, b);
          end else if (!sm_crc_mode) begin
            r.tx_byte = sm_sum;
            sm_phase = PH_ANSWER;
          end else if (int'(sm_slot) == 3 + BLOCK_BYTES) begin
            r.tx_byte = sm_crc[15:8];
          end else begin
            r.tx_byte = sm_crc[7:0];
            sm_phase = PH_ANSWER;
          end
          sm_slot = sm_slot + 8'd1;
        end else if (sm_phase == PH_EOT) begin
          r.tx_valid = 1'b1;
          r.tx_byte = CH_EOT;
          sm_phase = PH_EOTWAIT;
        end
      end
      default: ;
    endcase
    r.phase_code = sm_phase;
    r.current_block = sm_block;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] d, input logic last,
                         input logic [3:0] ph, input logic taken);
    stim_row_t row;
    row.op = op;
    row.d = d;
    row.last = last;
    row.typed = 1'b1;
    row.res.tx_valid = 1'b0;
    row.res.tx_byte = 8'h00;
    row.res.phase_code = ph;
    row.res.current_block = 8'd1;
    row.res.payload_taken = taken;
    stim_rows.push_back(row);
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] d, input logic last,
                           input bit typed, input xmbs_result_t typed_res);
    xmbs_result_t r;
    logic [3:0] ph_prev;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.data_byte <= d;
    in_ch.last_payload <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ph_prev = sm_phase;
    model_transfer(op, d, last, r);
    expected_tx_q.push_back(typed ? typed_res : r);
    if (ph_prev == PH_ANSWER && sm_phase == PH_LOAD) blocks_done++;
    items_in++;
  endtask

  task automatic pick_next(output logic [1:0] op, output logic [7:0] d, output logic last);
    int roll;
    roll = $urandom_range(0, 99);
    op = OP_TX_SLOT;
    d = 8'($urandom_range(0, 255));
    last = 1'($urandom_range(0, 1));
    case (sm_phase)
      PH_LOAD: begin
        if (roll < 4) begin
          case ($urandom_range(0, 2))
            0: op = OP_LINE_RX;
            1: op = OP_TX_SLOT;
            default: op = OP_NONE;
          endcase
        end else begin
          op = OP_LOAD;
          if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          last = (blocks_done == plan_blocks - 1) && (sm_fill == final_len - 1);
        end
      end
      PH_SEND, PH_EOT: begin
        if (roll < 4) begin
          case ($urandom_range(0, 2))
            0: op = OP_LINE_RX;
            1: op = OP_LOAD;
            default: op = OP_NONE;
          endcase
        end
      end
      PH_ANSWER: begin
        if (roll < 5) begin
          case ($urandom_range(0, 3))
            0: begin
              op = OP_LINE_RX;
              d = 8'h00;
            end
            1: op = OP_TX_SLOT;
            2: op = OP_LOAD;
            default: op = OP_NONE;
          endcase
        end else begin
          op = OP_LINE_RX;
          if (roll < 17) begin
            d = CH_NAK;
          end else if (sm_final && end_by_cancel) begin
            d = CH_CAN;
          end else if (roll < 75) begin
            d = CH_ACK;
          end else begin
            while (d == 8'h00 || d == CH_NAK || d == CH_CAN) d = 8'($urandom_range(1, 255));
          end
        end
      end
      PH_EOTWAIT: begin
        op = OP_LINE_RX;
        if (roll < 10) begin
          d = 8'h00;
        end else if (roll < 30) begin
          while (d == CH_ACK) d = 8'($urandom_range(0, 255));
        end else begin
          d = CH_ACK;
        end
      end
      default: op = 2'($urandom_range(0, 3));
    endcase
  endtask

  initial begin
    logic [7:0] start_byte;
    logic [1:0] op;
    logic [7:0] d;
    logic last;
    xmbs_result_t none;
    none = '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_NONE;
    in_ch.data_byte <= 8'h00;
    in_ch.last_payload <= 1'b0;
    sm_phase = PH_START;
    sm_crc_mode = 1'b0;
    sm_block = 8'd1;
    sm_fill = 0;
    sm_final = 1'b0;
    sm_slot = 8'd0;
    sm_sum = 8'd0;
    sm_crc = 16'd0;
    start_byte = $urandom_range(0, 1) ? CH_C : CH_NAK;
    final_len = $urandom_range(0, 1) ? BLOCK_BYTES : $urandom_range(1, 40);
    plan_blocks = (final_len == BLOCK_BYTES) ? 1 : 2;
    end_by_cancel = ($urandom_range(0, 2) == 0);

    add_row(OP_TX_SLOT, 8'h00, 1'b0, PH_START, 1'b0);
    add_row(OP_LOAD,    8'hFF, 1'b1, PH_START, 1'b0);
    add_row(OP_NONE,    8'hFF, 1'b1, PH_START, 1'b0);
    add_row(OP_LINE_RX, 8'h00, 1'b0, PH_START, 1'b0);
    add_row(OP_LINE_RX, start_byte, 1'b0, PH_LOAD, 1'b0);
    add_row(OP_LINE_RX, CH_CAN, 1'b1, PH_LOAD, 1'b0);
    add_row(OP_TX_SLOT, 8'hFF, 1'b1, PH_LOAD, 1'b0);
    add_row(OP_NONE,    8'h00, 1'b0, PH_LOAD, 1'b0);
    add_row(OP_LOAD,    8'h00, 1'b0, PH_LOAD, 1'b1);
    add_row(OP_LOAD,    8'hFF, 1'b0, PH_LOAD, 1'b1);
    add_row(OP_LOAD,    8'h80, 1'b0, PH_LOAD, 1'b1);
    add_row(OP_LOAD,    8'h7F, 1'b0, PH_LOAD, 1'b1);
    add_row(OP_LINE_RX, CH_NAK, 1'b0, PH_LOAD, 1'b0);
    add_row(OP_LINE_RX, CH_ACK, 1'b0, PH_LOAD, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      push_item(stim_rows[i].op, stim_rows[i].d, stim_rows[i].last,
                stim_rows[i].typed, stim_rows[i].res);
    end

    while (sm_phase != PH_DONE && sm_phase != PH_CANCEL) begin
      case ((items_in / PHASE_ITEMS) % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 71; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 71; end
        default: begin in_idle_pct = 28; out_stall_pct = 28; end
      endcase
      if (items_in >= HOLD_AT_ITEM && !hold_fired) begin
        hold_fired = 1'b1;
        hold_req = 1'b1;
      end
      if (items_in >= PAUSE_AT_ITEM && !pause_fired) begin
        pause_fired = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_tx_q.size() != 0) @(posedge clk);
      end
      pick_next(op, d, last);
      push_item(op, d, last, 1'b0, none);
    end

    // terminal phase: everything is ignored
    repeat (12) begin
      pick_next(op, d, last);
      push_item(op, d, last, 1'b0, none);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_tx_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d command transfers and %0d checked results, %0d blocks advanced",
             items_in, results_seen, blocks_done);
    $display("Check mode %s, last block %0d bytes, session ended in phase %0d, %0d mismatches",
             sm_crc_mode ? "CRC-16" : "checksum", final_len, sm_phase, mismatches);
    if (mismatches == 0 && expected_tx_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: check each result transfer, then choose next ready
  always @(posedge clk) begin
    xmbs_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_tx_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tx_valid=%0b tx_byte=%02h phase=%0d block=%0d taken=%0b",
                   out_ch.tx_valid, out_ch.tx_byte, out_ch.phase_code,
                   out_ch.current_block, out_ch.payload_taken);
      end else begin
        e = expected_tx_q.pop_front();
        if (out_ch.tx_valid !== e.tx_valid || out_ch.tx_byte !== e.tx_byte ||
            out_ch.phase_code !== e.phase_code || out_ch.current_block !== e.current_block ||
            out_ch.payload_taken !== e.payload_taken) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch %0d: exp tx_valid=%0b tx_byte=%02h phase=%0d block=%0d taken=%0b",
                     mismatches, e.tx_valid, e.tx_byte, e.phase_code, e.current_block,
                     e.payload_taken);
            $display("             got tx_valid=%0b tx_byte=%02h phase=%0d block=%0d taken=%0b",
                     out_ch.tx_valid, out_ch.tx_byte, out_ch.phase_code,
                     out_ch.current_block, out_ch.payload_taken);
          end
        end
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_tx_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// ----- xmodem_block_sender_unit.f -----
hdl/xmbs_pkg.sv
hdl/xmbs_if.sv
hdl/xmodem_block_sender_unit.sv
hdl/xmbs_checker.sv
tb/tb_top.sv
